### rtl/core/lsafg_pkg.sv
// ----------------------------------------------------------------------------
// lsafg_pkg
// Shared types, register indexes, mode codes and a helper function for the
// LED strip animation frame generator.
// ----------------------------------------------------------------------------
package lsafg_pkg;

   localparam int MaxLeds = 64;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_BREATH = 2'd1;
   localparam logic [1:0] MODE_CHASE = 2'd2;
   localparam logic [1:0] MODE_GRAD  = 2'd3;

   localparam logic [2:0] REG_MODE        = 3'd0;
   localparam logic [2:0] REG_LED_COUNT   = 3'd1;
   localparam logic [2:0] REG_WAIT_MS     = 3'd2;
   localparam logic [2:0] REG_MAIN_COLOR  = 3'd3;
   localparam logic [2:0] REG_START_COLOR = 3'd4;
   localparam logic [2:0] REG_END_COLOR   = 3'd5;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_WRAP   = 7'b0000100,
      ST_SETUP  = 7'b0001000,
      ST_PIXEL  = 7'b0010000,
      ST_DIVIDE = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load_req;
      logic frame_start;
      logic wrap_sub;
      logic setup;
      logic div_load;
      logic div_step;
      logic emit;
      logic pix_next;
   } cmd_type;

   typedef struct packed {
      logic due;
      logic wrap_more;
      logic skip;
      logic use_div;
      logic div_last;
      logic rsp_free;
      logic frame_end;
   } status_type;

   // comet tail dimming: divide by (7 - j) for j in 0..5, by reciprocal multiply
   function automatic logic [7:0] chase_div(input logic [7:0] x, input logic [2:0] j);
      logic [18:0] xw;
      logic [7:0]  q;
      xw = 19'(x);
      case (j)
         3'd0:    q = 8'((xw * 19'd293) >> 11);
         3'd1:    q = 8'((xw * 19'd171) >> 10);
         3'd2:    q = 8'((xw * 19'd205) >> 10);
         3'd3:    q = {2'd0, x[7:2]};
         3'd4:    q = 8'((xw * 19'd171) >> 9);
         3'd5:    q = {1'b0, x[7:1]};
         default: q = x;
      endcase
      return q;
   endfunction

endpackage

### rtl/core/lsafg_ctrl.sv
// ----------------------------------------------------------------------------
// lsafg_ctrl
// Frame sequencer: checks frame timing, wraps the step, walks the pixels and
// paces the gradient divider and the result register.
// ----------------------------------------------------------------------------
module lsafg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lsafg_pkg::status_type status,
   output lsafg_pkg::cmd_type    cmd
);

   lsafg_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lsafg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = lsafg_pkg::ST_CHECK;
            end
         end
         lsafg_pkg::ST_CHECK: begin
            if (status.due) begin
               cmd.frame_start = 1'b1;
               state_in        = lsafg_pkg::ST_WRAP;
            end else begin
               state_in = lsafg_pkg::ST_IDLE;
            end
         end
         lsafg_pkg::ST_WRAP: begin
            if (status.wrap_more) begin
               cmd.wrap_sub = 1'b1;
            end else begin
               state_in = lsafg_pkg::ST_SETUP;
            end
         end
         lsafg_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = lsafg_pkg::ST_PIXEL;
         end
         lsafg_pkg::ST_PIXEL: begin
            if (status.skip) begin
               cmd.pix_next = 1'b1;
               if (status.frame_end) begin
                  state_in = lsafg_pkg::ST_IDLE;
               end
            end else if (status.use_div) begin
               cmd.div_load = 1'b1;
               state_in     = lsafg_pkg::ST_DIVIDE;
            end else begin
               state_in = lsafg_pkg::ST_EMIT;
            end
         end
         lsafg_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = lsafg_pkg::ST_EMIT;
            end
         end
         lsafg_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit     = 1'b1;
               cmd.pix_next = 1'b1;
               state_in     = status.frame_end ? lsafg_pkg::ST_IDLE : lsafg_pkg::ST_PIXEL;
            end
         end
         default: begin
            state_in = lsafg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsafg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/lsafg_dpath.sv
// ----------------------------------------------------------------------------
// lsafg_dpath
// Configuration registers, animation state, pixel counters, gradient divider
// and the result register.
// ----------------------------------------------------------------------------
module lsafg_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic [31:0]           req_now_ms,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [5:0]            rsp_pixel_index,
   output logic [7:0]            rsp_red_level,
   output logic [7:0]            rsp_green_level,
   output logic [7:0]            rsp_blue_level,
   output logic [7:0]            rsp_brightness_level,
   output logic                  rsp_last_pixel,
   input  lsafg_pkg::cmd_type    cmd,
   output lsafg_pkg::status_type status
);

   logic [1:0]  mode_ff;
   logic [6:0]  led_count_ff;
   logic [31:0] wait_ms_ff;
   logic [23:0] main_color_ff, start_color_ff, end_color_ff;

   logic [31:0] now_ff, last_ff;
   logic [6:0]  step_ff, step_in;
   logic [1:0]  prev_mode_ff;
   logic [7:0]  bright_ff, bright_in;
   logic [6:0]  j_ff, pos_ff, pos_in, last_k_ff;
   logic [2:0]  div_cnt_ff;
   logic [13:0] rem_ff [3];
   logic [7:0]  quo_ff [3];

   logic        rsp_valid_ff;
   logic [5:0]  pix_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, brt_ff;
   logic        last_pix_ff;

   logic [6:0]  eff_l, bound, chase_n, two_n, total, step_mod, step_dist;
   logic [5:0]  half_n, grad_k;
   logic [13:0] num [3];
   logic [13:0] dsh;
   logic [8:0]  dist5;
   logic        frame_end;
   logic [7:0]  main_ch [3];
   logic [7:0]  col [3];

   always_comb begin
      if (led_count_ff < 7'd2) begin
         eff_l = 7'd2;
      end else if (led_count_ff > 7'(lsafg_pkg::MaxLeds)) begin
         eff_l = 7'(lsafg_pkg::MaxLeds);
      end else begin
         eff_l = led_count_ff;
      end
      chase_n = eff_l + 7'd10;
      half_n  = eff_l[6:1];
      two_n   = {eff_l[6:1], 1'b0};
      bound   = (mode_ff == lsafg_pkg::MODE_CHASE) ? chase_n : eff_l;
      case (mode_ff)
         lsafg_pkg::MODE_CHASE: total = chase_n;
         lsafg_pkg::MODE_GRAD:  total = two_n;
         default:               total = eff_l;
      endcase
      frame_end = (j_ff == total - 7'd1);
      grad_k    = (pos_ff[5:0] > half_n) ? pos_ff[5:0] - half_n : half_n - pos_ff[5:0];
      dsh       = 14'({8'd0, half_n} << div_cnt_ff);
      step_dist = (step_ff > 7'd20) ? step_ff - 7'd20 : 7'd20 - step_ff;
      dist5     = 9'(step_dist) * 9'd5;
      step_mod  = (step_ff >= two_n) ? step_ff - two_n : step_ff;
      for (int c = 0; c < 3; c++) begin
         num[c] = 14'(end_color_ff[8*c +: 8]) * 14'(grad_k)
                + 14'(start_color_ff[8*c +: 8]) * 14'(half_n - grad_k);
         main_ch[c] = main_color_ff[8*c +: 8];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (mode_ff)
            lsafg_pkg::MODE_BREATH: col[c] = main_ch[c];
            lsafg_pkg::MODE_CHASE: begin
               if (j_ff <= 7'd5) begin
                  col[c] = (c == 0) ? main_ch[c] : lsafg_pkg::chase_div(main_ch[c], j_ff[2:0]);
               end else if (j_ff <= 7'd10) begin
                  col[c] = main_ch[c];
               end else begin
                  col[c] = 8'd0;
               end
            end
            lsafg_pkg::MODE_GRAD:  col[c] = quo_ff[c];
            default:               col[c] = 8'd0;
         endcase
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.frame_start) begin
         step_in = (prev_mode_ff != mode_ff) ? 7'd0 : step_ff + 7'd1;
      end else if (cmd.wrap_sub) begin
         step_in = step_ff - bound;
      end
      bright_in = bright_ff;
      case (mode_ff)
         lsafg_pkg::MODE_BREATH: bright_in = dist5[8:1];
         lsafg_pkg::MODE_CHASE,
         lsafg_pkg::MODE_GRAD:   bright_in = 8'd50;
         default:                bright_in = bright_ff;
      endcase
      pos_in = pos_ff + 7'd1;
      if (mode_ff == lsafg_pkg::MODE_CHASE && pos_in == chase_n) begin
         pos_in = 7'd0;
      end else if (mode_ff == lsafg_pkg::MODE_GRAD && pos_in == two_n) begin
         pos_in = 7'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= lsafg_pkg::MODE_OFF;
         led_count_ff   <= 7'd8;
         wait_ms_ff     <= 32'd50;
         main_color_ff  <= '0;
         start_color_ff <= '0;
         end_color_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            lsafg_pkg::REG_MODE:        mode_ff        <= csr_data[1:0];
            lsafg_pkg::REG_LED_COUNT:   led_count_ff   <= csr_data[6:0];
            lsafg_pkg::REG_WAIT_MS:     wait_ms_ff     <= csr_data;
            lsafg_pkg::REG_MAIN_COLOR:  main_color_ff  <= csr_data[23:0];
            lsafg_pkg::REG_START_COLOR: start_color_ff <= csr_data[23:0];
            lsafg_pkg::REG_END_COLOR:   end_color_ff   <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         last_ff      <= '0;
         prev_mode_ff <= lsafg_pkg::MODE_OFF;
         bright_ff    <= 8'd255;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (cmd.frame_start) begin
            last_ff      <= now_ff;
            prev_mode_ff <= mode_ff;
         end
         if (cmd.setup) begin
            bright_ff <= bright_in;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         now_ff <= req_now_ms;
      end
      if (cmd.setup) begin
         j_ff <= '0;
         case (mode_ff)
            lsafg_pkg::MODE_CHASE: pos_ff <= step_ff;
            lsafg_pkg::MODE_GRAD:  pos_ff <= step_mod;
            default:               pos_ff <= '0;
         endcase
         last_k_ff <= (step_ff == 7'd0 || step_ff > eff_l) ? eff_l - 7'd1 : step_ff - 7'd1;
      end else if (cmd.pix_next) begin
         j_ff   <= j_ff + 7'd1;
         pos_ff <= pos_in;
      end
      if (cmd.div_load) begin
         div_cnt_ff <= 3'd7;
         for (int c = 0; c < 3; c++) begin
            rem_ff[c] <= num[c];
            quo_ff[c] <= '0;
         end
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - 3'd1;
         for (int c = 0; c < 3; c++) begin
            if (rem_ff[c] >= dsh) begin
               rem_ff[c]             <= rem_ff[c] - dsh;
               quo_ff[c][div_cnt_ff] <= 1'b1;
            end
         end
      end
      if (cmd.emit) begin
         pix_ff      <= (mode_ff == lsafg_pkg::MODE_CHASE) ? pos_ff[5:0] : j_ff[5:0];
         red_ff      <= col[2];
         green_ff    <= col[1];
         blue_ff     <= col[0];
         brt_ff      <= bright_ff;
         last_pix_ff <= (mode_ff == lsafg_pkg::MODE_CHASE) ? (pos_ff == last_k_ff) : frame_end;
      end
   end

   assign status.due       = (now_ff - last_ff) > wait_ms_ff;
   assign status.wrap_more = step_ff >= bound;
   assign status.skip      = (mode_ff == lsafg_pkg::MODE_CHASE) && (pos_ff >= eff_l);
   assign status.use_div   = (mode_ff == lsafg_pkg::MODE_GRAD);
   assign status.div_last  = (div_cnt_ff == 3'd0);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign status.frame_end = frame_end;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pixel_index      = pix_ff;
   assign rsp_red_level        = red_ff;
   assign rsp_green_level      = green_ff;
   assign rsp_blue_level       = blue_ff;
   assign rsp_brightness_level = brt_ff;
   assign rsp_last_pixel       = last_pix_ff;

endmodule

### rtl/core/led_strip_animation_frame_generator.sv
// ----------------------------------------------------------------------------
// led_strip_animation_frame_generator
// Each request carries a millisecond timestamp. When more than wait_ms has
// passed since the last frame, the animation step advances and one pixel
// write per LED (count clamped to 2..64, rounded down to even in gradient
// mode) is sent on the rsp_ channel; the last write of a frame has
// rsp_last_pixel set. Requests that fall inside the frame interval give no
// write. Registers are written through csr_ (index 0..5); the user must
// write them only while idle, which the block itself does not enforce. The
// sequencer checks timing, subtracts the step bound until the step wraps,
// runs a setup step, then handles each pixel in turn; in gradient mode a
// restoring divider per color channel sets the pace. One request is
// processed at a time; req_ready is high only between frames. When the
// receiver stalls, the current write holds in the result register and the
// sequencer waits. Reset restores the register defaults (mode off, 8 LEDs,
// 50 ms), clears the step and the frame time, and sets brightness to full.
// ----------------------------------------------------------------------------
module led_strip_animation_frame_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_pixel_index,
   output logic [7:0]  rsp_red_level,
   output logic [7:0]  rsp_green_level,
   output logic [7:0]  rsp_blue_level,
   output logic [7:0]  rsp_brightness_level,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   lsafg_pkg::cmd_type    cmd;
   lsafg_pkg::status_type status;

   assign csr_ready = 1'b1;

   lsafg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsafg_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_now_ms           (req_now_ms),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_pixel_index      (rsp_pixel_index),
      .rsp_red_level        (rsp_red_level),
      .rsp_green_level      (rsp_green_level),
      .rsp_blue_level       (rsp_blue_level),
      .rsp_brightness_level (rsp_brightness_level),
      .rsp_last_pixel       (rsp_last_pixel),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

### test/led_strip_animation_frame_generator_tb.sv
// ----------------------------------------------------------------------------
// led_strip_animation_frame_generator_tb
// Self-checking bench for the animation frame generator. A directed table
// followed by random register settings and timestamp sequences exercises all
// four modes. Every accepted timestamp is run through a frame predictor, and
// each pixel write is compared field by field. Both sides stall at random.
// ----------------------------------------------------------------------------
module led_strip_animation_frame_generator_tb;

   typedef struct packed {
      logic [5:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] bright;
      logic       last;
   } pixel_type;

   typedef enum logic {ROW_CFG, ROW_REQ} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   index;
      logic [31:0]  data;
      int           writes;
      logic         chk;
      pixel_type    first;
   } row_type;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [31:0] req_now_ms;
   logic        rsp_valid, rsp_ready;
   logic [5:0]  rsp_pixel_index;
   logic [7:0]  rsp_red_level, rsp_green_level, rsp_blue_level, rsp_brightness_level;
   logic        rsp_last_pixel;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   led_strip_animation_frame_generator dut (.*);

   // shadow of registers and animation state
   logic [1:0]  mode_r;
   logic [6:0]  count_r;
   logic [31:0] wait_r;
   logic [23:0] main_r, start_r, end_r;
   int unsigned step_r;
   logic [31:0] last_time_r;
   logic [1:0]  prev_mode_r;
   logic [7:0]  bright_r;

   pixel_type   pixel_q[$];
   int          errors = 0;
   int          frames = 0;
   int          writes_seen = 0;
   int          requests = 0;
   int          idle_cnt = 0;
   logic        quiet = 0;
   logic        long_hold = 0;
   logic [31:0] now_t;
   row_type     rows[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
         lsafg_pkg::REG_MODE:        mode_r = val[1:0];
         lsafg_pkg::REG_LED_COUNT:   count_r = val[6:0];
         lsafg_pkg::REG_WAIT_MS:     wait_r = val;
         lsafg_pkg::REG_MAIN_COLOR:  main_r = val[23:0];
         lsafg_pkg::REG_START_COLOR: start_r = val[23:0];
         lsafg_pkg::REG_END_COLOR:   end_r = val[23:0];
         default: ;
      endcase
   endfunction

   function automatic void push_pixel(input int unsigned idx, input int unsigned r,
                                      input int unsigned g, input int unsigned b);
      pixel_type p;
      p.index = idx[5:0];
      p.red = r[7:0];
      p.green = g[7:0];
      p.blue = b[7:0];
      p.bright = bright_r;
      p.last = 1'b0;
      pixel_q.push_back(p);
   endfunction

   function automatic void predict_frame(input logic [31:0] now);
      logic [31:0] diff;
      int unsigned lc, bnd, n, j, k, m, d, mr, mg, mb;
      int unsigned sr, sg, sb, er, eg, eb;
      diff = now - last_time_r;
      if (diff <= wait_r) return;
      lc = count_r;
      if (lc < 2) lc = 2;
      if (lc > lsafg_pkg::MaxLeds) lc = lsafg_pkg::MaxLeds;
      bnd = (mode_r == lsafg_pkg::MODE_CHASE) ? lc + 10 : lc;
      step_r = (step_r + 1) % bnd;
      if (prev_mode_r != mode_r) begin
         step_r = 0;
         prev_mode_r = mode_r;
      end
      mr = main_r[23:16]; mg = main_r[15:8]; mb = main_r[7:0];
      sr = start_r[23:16]; sg = start_r[15:8]; sb = start_r[7:0];
      er = end_r[23:16]; eg = end_r[15:8]; eb = end_r[7:0];
      case (mode_r)
         lsafg_pkg::MODE_OFF: begin
            for (j = 0; j < lc; j++) push_pixel(j, 0, 0, 0);
         end
         lsafg_pkg::MODE_BREATH: begin
            d = (step_r > 20) ? step_r - 20 : 20 - step_r;
            bright_r = 8'((d * 5) >> 1);
            for (j = 0; j < lc; j++) push_pixel(j, mr, mg, mb);
         end
         lsafg_pkg::MODE_CHASE: begin
            bright_r = 8'd50;
            n = lc + 10;
            for (j = 0; j < n; j++) begin
               k = (step_r + j) % n;
               if (k < lc) begin
                  if (j <= 5) push_pixel(k, mr / (7 - j), mg / (7 - j), mb);
                  else if (j <= 10) push_pixel(k, mr, mg, mb);
                  else push_pixel(k, 0, 0, 0);
               end
            end
         end
         default: begin
            bright_r = 8'd50;
            n = lc / 2;
            for (j = 0; j < 2 * n; j++) begin
               m = (step_r + j) % (2 * n);
               k = (m > n) ? m - n : n - m;
               push_pixel(j, (er * k + sr * (n - k)) / n, (eg * k + sg * (n - k)) / n,
                          (eb * k + sb * (n - k)) / n);
            end
         end
      endcase
      pixel_q[$].last = 1'b1;
      last_time_r = now;
      frames++;
   endfunction

   // compare pixel writes
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_pixel_index, rsp_red_level, rsp_green_level, rsp_blue_level,
                 rsp_brightness_level, rsp_last_pixel};
         writes_seen++;
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected pixel write %p", $time, got);
            errors++;
         end else begin
            want = pixel_q.pop_front();
            if (got.index !== want.index)
               $display("%0t: pixel_index exp %0d got %0d", $time, want.index, got.index);
            if (got.red !== want.red)
               $display("%0t: red_level exp %0d got %0d", $time, want.red, got.red);
            if (got.green !== want.green)
               $display("%0t: green_level exp %0d got %0d", $time, want.green, got.green);
            if (got.blue !== want.blue)
               $display("%0t: blue_level exp %0d got %0d", $time, want.blue, got.blue);
            if (got.bright !== want.bright)
               $display("%0t: brightness_level exp %0d got %0d", $time, want.bright,
                        got.bright);
            if (got.last !== want.last)
               $display("%0t: last_pixel exp %0d got %0d", $time, want.last, got.last);
            if (got !== want) errors++;
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else
            rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cnt <= 0;
      else if (idle_cnt == 5000) begin
         $display("tb: failure");
         $finish;
      end else
         idle_cnt <= idle_cnt + 1;
   end

   task automatic drain();
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
   endtask

   task automatic send_now(input logic [31:0] now, output int writes);
      int size_before;
      req_valid <= 1'b1;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      size_before = pixel_q.size();
      predict_frame(now);
      writes = pixel_q.size() - size_before;
      requests++;
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   function automatic row_type cfg_row(input logic [2:0] idx, input logic [31:0] val);
      row_type r;
      r = '{ROW_CFG, idx, val, -1, 1'b0, '0};
      return r;
   endfunction

   function automatic row_type req_row(input logic [31:0] now, input int writes,
                                       input logic chk, input pixel_type first);
      row_type r;
      r = '{ROW_REQ, 3'd0, now, writes, chk, first};
      return r;
   endfunction

   function automatic logic [31:0] pick_count();
      case ($urandom_range(0, 7))
         0: return 32'($urandom_range(0, 1));
         1: return 32'd64;
         2: return 32'($urandom_range(65, 127));
         3: return 32'd2;
         default: return 32'($urandom_range(2, 12));
      endcase
   endfunction

   initial begin
      int got_writes, i, p, it;
      logic [31:0] w;
      reset = 1'b1;
      req_valid = 1'b0; req_now_ms = '0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      mode_r = lsafg_pkg::MODE_OFF; count_r = 7'd8; wait_r = 32'd50;
      main_r = '0; start_r = '0; end_r = '0;
      step_r = 0; last_time_r = '0; prev_mode_r = lsafg_pkg::MODE_OFF; bright_r = 8'd255;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back(req_row(32'd10, 0, 1'b0, '0));
      rows.push_back(req_row(32'd51, 8, 1'b1, '{6'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0}));
      rows.push_back(cfg_row(lsafg_pkg::REG_MODE, {30'd0, lsafg_pkg::MODE_BREATH}));
      rows.push_back(cfg_row(lsafg_pkg::REG_MAIN_COLOR, 32'hFFFFFF));
      rows.push_back(cfg_row(lsafg_pkg::REG_WAIT_MS, 32'd0));
      rows.push_back(req_row(32'd52, 8, 1'b1, '{6'd0, 8'd255, 8'd255, 8'd255, 8'd50, 1'b0}));
      rows.push_back(req_row(32'd52, 0, 1'b0, '0));
      rows.push_back(req_row(32'd53, 8, 1'b1, '{6'd0, 8'd255, 8'd255, 8'd255, 8'd47, 1'b0}));
      rows.push_back(cfg_row(lsafg_pkg::REG_LED_COUNT, 32'd0));
      rows.push_back(cfg_row(lsafg_pkg::REG_MODE, {30'd0, lsafg_pkg::MODE_CHASE}));
      rows.push_back(cfg_row(lsafg_pkg::REG_MAIN_COLOR, 32'hFF00FF));
      rows.push_back(req_row(32'd100, 2, 1'b0, '0));
      rows.push_back(req_row(32'd101, -1, 1'b0, '0));
      rows.push_back(cfg_row(lsafg_pkg::REG_LED_COUNT, 32'd127));
      rows.push_back(req_row(32'd102, 64, 1'b0, '0));
      rows.push_back(cfg_row(lsafg_pkg::REG_MODE, {30'd0, lsafg_pkg::MODE_GRAD}));
      rows.push_back(cfg_row(lsafg_pkg::REG_START_COLOR, 32'h000000));
      rows.push_back(cfg_row(lsafg_pkg::REG_END_COLOR, 32'hFFFFFF));
      rows.push_back(cfg_row(lsafg_pkg::REG_LED_COUNT, 32'd1));
      rows.push_back(req_row(32'd103, 2, 1'b0, '0));
      rows.push_back(req_row(32'd104, 2, 1'b0, '0));
      rows.push_back(cfg_row(3'd6, 32'hFFFF_FFFF));
      rows.push_back(cfg_row(3'd7, 32'h1234_5678));
      rows.push_back(cfg_row(lsafg_pkg::REG_WAIT_MS, 32'hFFFF_FFFE));
      rows.push_back(req_row(32'hFFFF_FFFF, 0, 1'b0, '0));
      rows.push_back(req_row(32'd103, 2, 1'b0, '0));

      for (i = 0; i < rows.size(); i++) begin
         if (rows[i].kind == ROW_CFG) begin
            if (i == 0 || rows[i - 1].kind != ROW_CFG) begin
               req_valid <= 1'b0;
               drain();
            end
            write_reg(rows[i].index, rows[i].data);
            if (i + 1 == rows.size() || rows[i + 1].kind != ROW_CFG) csr_valid <= 1'b0;
         end else begin
            send_now(rows[i].data, got_writes);
            if (rows[i].writes >= 0 && got_writes != rows[i].writes) begin
               $display("%0t: row %0d writes exp %0d got %0d", $time, i, rows[i].writes,
                        got_writes);
               errors++;
            end
            if (rows[i].chk && got_writes > 0 &&
                pixel_q[pixel_q.size() - got_writes] !== rows[i].first) begin
               $display("%0t: row %0d first write exp %p got %p", $time, i, rows[i].first,
                        pixel_q[pixel_q.size() - got_writes]);
               errors++;
            end
            sender_gap();
         end
      end

      now_t = 32'd200;
      for (p = 0; p < 9; p++) begin
         req_valid <= 1'b0;
         drain();
         if (p == 8) quiet = 1'b1;
         write_reg(lsafg_pkg::REG_MODE, 32'($urandom_range(0, 3)));
         write_reg(lsafg_pkg::REG_LED_COUNT, pick_count());
         write_reg(lsafg_pkg::REG_WAIT_MS, ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF
                                                  : 32'($urandom_range(0, 8)));
         write_reg(lsafg_pkg::REG_MAIN_COLOR,
                   ($urandom_range(0, 4) == 0) ? 32'hFFFFFF : $urandom);
         write_reg(lsafg_pkg::REG_START_COLOR, ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom);
         write_reg(lsafg_pkg::REG_END_COLOR,
                   ($urandom_range(0, 4) == 0) ? 32'hFFFFFF : $urandom);
         if (p == 2 || p == 6) write_reg(lsafg_pkg::REG_WAIT_MS, 32'd3);
         csr_valid <= 1'b0;
         if (p == 4) now_t = 32'hFFFF_FFF0;
         if (p == 2) long_hold = 1'b1;
         for (it = 0; it < 11; it++) begin
            if (p == 6 && it == 5) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pixel_q.size() != 0);
            end
            w = wait_r;
            case ($urandom_range(0, 9))
               0: now_t = $urandom;
               1: now_t = now_t + $urandom_range(0, 1);
               default: now_t = now_t + ((w > 32'd100) ? 32'd5 : w + $urandom_range(1, 4));
            endcase
            send_now(now_t, got_writes);
            sender_gap();
         end
      end

      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d timestamps, %0d frames, %0d pixel writes across all modes,",
               requests, frames, writes_seen);
      $display("led counts clamped both ways, wait extremes, time wrap and stalls");
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
